>>> src/modular_exponentiation_defines.svh
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH
// implication check, reset aware
`define MME_ASSERT_IMP(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
// next-cycle check, reset aware
`define MME_ASSERT_NXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`endif

>>> src/mme_pkg.sv
package mme_pkg;
    localparam int OPERAND_BITS = 31;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_OUT
    } state_t;
endpackage

>>> src/mme_if.sv
interface mme_in_if #(parameter int W = 31);
    logic         valid;
    logic         ready;
    logic [W-1:0] base_value;
    logic [W-1:0] exponent;
    logic [W-1:0] modulus;
    modport source (output valid, base_value, exponent, modulus, input ready);
    modport sink (input valid, base_value, exponent, modulus, output ready);
endinterface

interface mme_out_if #(parameter int W = 31);
    logic         valid;
    logic         ready;
    logic [W-1:0] power_result;
    logic         bad_modulus;
    modport source (output valid, power_result, bad_modulus, input ready);
    modport sink (input valid, power_result, bad_modulus, output ready);
endinterface

>>> src/mme_cell.sv
module mme_cell
    import mme_pkg::*;
#(
    parameter int W = OPERAND_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [W-1:0] in_acc,
    input  logic [W-1:0] a,
    input  logic         b_bit,
    input  logic [W-1:0] m,
    output logic         out_valid,
    output logic [W-1:0] out_acc
);
    logic         valid_reg;
    logic [W-1:0] acc_reg;
    logic [W-1:0] acc_next;
    logic [W:0]   dbl;
    logic [W:0]   red1;
    logic [W:0]   sum;
    logic [W:0]   red2;
    logic [W:0]   m_ext;

    // one shift-and-add step: acc = 2*acc (+a) mod m
    always_comb
    begin
        m_ext = {1'b0, m};
        dbl   = {in_acc, 1'b0};
        red1  = (dbl >= m_ext) ? dbl - m_ext : dbl;
        sum   = red1 + (b_bit ? {1'b0, a} : '0);
        red2  = (sum >= m_ext) ? sum - m_ext : sum;
        acc_next = red2[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign out_valid = valid_reg;
    assign out_acc   = acc_reg;
endmodule

>>> src/modular_exponentiation.sv
// channel   dir  fields
// in_ch     in   base_value, exponent, modulus
// out_ch    out  power_result, bad_modulus
// one item makes W+1 chain passes, one for the base reduction and one per exponent
// bit, between the idle and output states
// a zero modulus skips the chain and goes from idle straight to the output state
// reset (rst_n low, async) returns to idle and drops out_ch.valid
// a stalled result holds out_ch and keeps the next item in the output state until taken
`include "modular_exponentiation_defines.svh"
module modular_exponentiation
    import mme_pkg::*;
#(
    parameter int W = OPERAND_BITS
) (
    input logic        clk,
    input logic        rst_n,
    mme_in_if.sink     in_ch,
    mme_out_if.source  out_ch
);
    localparam int CW = $clog2(W + 2);
    localparam logic [CW-1:0] LAST_STEP = CW'(W);

    state_t        state_reg, state_next;
    logic [W-1:0]  base_reg, exp_reg, mod_reg, acc_reg, sq_reg;
    logic [CW-1:0] step_reg;
    logic          bad_reg;
    logic          out_valid_reg;
    logic [W-1:0]  out_res_reg;
    logic          out_bad_reg;
    logic          in_ready, issue, out_load, done;

    logic          v0 [0:W];
    logic          v1 [0:W];
    logic [W-1:0]  c0 [0:W];
    logic [W-1:0]  c1 [0:W];
    logic [W-1:0]  a0, b0;

    // lane 0: base reduction, then acc*sq; lane 1: sq*sq
    always_comb
    begin
        if (step_reg == '0)
        begin
            a0 = (mod_reg == W'(1)) ? '0 : W'(1);
            b0 = base_reg;
        end
        else
        begin
            a0 = acc_reg;
            b0 = sq_reg;
        end
    end

    assign v0[0] = issue;
    assign v1[0] = issue;
    assign c0[0] = '0;
    assign c1[0] = '0;

    // multiply chain, msb of the multiplier first
    genvar k;
    generate
        for (k = 0; k < W; k++)
        begin : g_cell
            mme_cell #(.W(W)) u_c0 (
                .clk(clk), .rst_n(rst_n), .in_valid(v0[k]), .in_acc(c0[k]),
                .a(a0), .b_bit(b0[W-1-k]), .m(mod_reg),
                .out_valid(v0[k+1]), .out_acc(c0[k+1])
            );
            mme_cell #(.W(W)) u_c1 (
                .clk(clk), .rst_n(rst_n), .in_valid(v1[k]), .in_acc(c1[k]),
                .a(sq_reg), .b_bit(sq_reg[W-1-k]), .m(mod_reg),
                .out_valid(v1[k+1]), .out_acc(c1[k+1])
            );
        end
    endgenerate

    assign done = v0[W];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                    state_next = (in_ch.modulus == '0) ? S_OUT : S_ISSUE;
            end
            S_ISSUE: state_next = S_WAIT;
            S_WAIT:
            begin
                if (done)
                    state_next = (step_reg == LAST_STEP) ? S_OUT : S_ISSUE;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            S_ISSUE: issue = 1'b1;
            S_WAIT:  ;
            S_OUT:   out_load = !out_valid_reg || out_ch.ready;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // operand and result registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_ch.valid)
        begin
            base_reg <= in_ch.base_value;
            exp_reg  <= in_ch.exponent;
            mod_reg  <= in_ch.modulus;
            bad_reg  <= (in_ch.modulus == '0);
            acc_reg  <= W'(1);
            step_reg <= '0;
        end
        else if (state_reg == S_WAIT && done)
        begin
            step_reg <= step_reg + CW'(1);
            if (step_reg == '0)
            begin
                sq_reg <= c0[W];
            end
            else
            begin
                if (exp_reg[0])
                    acc_reg <= c0[W];
                sq_reg  <= c1[W];
                exp_reg <= exp_reg >> 1;
            end
        end
        if (out_load)
        begin
            out_res_reg <= bad_reg ? '0 : acc_reg;
            out_bad_reg <= bad_reg;
        end
    end

    assign in_ch.ready         = in_ready;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.power_result = out_res_reg;
    assign out_ch.bad_modulus  = out_bad_reg;

    `MME_ASSERT_IMP(a_done_in_wait, done, state_reg == S_WAIT, "chain finished outside wait")
    `MME_ASSERT_NXT(a_issue_flows, issue, v0[1] && v1[1], "chain did not take issued step")
    `MME_ASSERT_IMP(a_bad_zero, out_valid_reg && out_bad_reg, out_res_reg == '0,
        "bad modulus with nonzero result")
    `MME_ASSERT_IMP(a_no_busy_accept, state_reg != S_IDLE, !in_ready, "accept while busy")
endmodule
